@@ src/battery_monitor_frame_decoder_unit_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef BATTERY_MONITOR_FRAME_DECODER_UNIT_DEFINES_SVH
`define BATTERY_MONITOR_FRAME_DECODER_UNIT_DEFINES_SVH

// Checked only outside reset.
`define BMFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define BMFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/bmfd_pkg.sv @@
`timescale 1ns / 1ps

package bmfd_pkg;

  localparam int FRAME_BYTES   = 58;
  localparam int CELL_COUNT    = 16;
  localparam int PAYLOAD_BYTES = 47;
  localparam int COUNT_W       = 7;
  localparam int COUNT_MAX     = 127;
  localparam int VALUE_W       = 28;
  localparam int QTY_W         = 4;
  localparam int QTY_COUNT     = 14;
  localparam int QTY_NO_CELL   = 11;
  localparam int CNT_W         = $clog2(QTY_COUNT + 1);

  localparam logic [7:0] MARK_KEEP     = 8'h58;  // 'X'
  localparam logic [7:0] MARK_NEG      = 8'h2D;  // '-'
  localparam int         CURRENT_SCALE = 125;
  localparam int         VOLT_SCALE    = 5;
  localparam int         TEMP_OFFSET   = 'h0114;

  typedef enum logic [1:0] {
    OUT_GOOD    = 2'd0,
    OUT_BAD_LEN = 2'd1,
    OUT_BAD_SUM = 2'd2
  } outcome_t;

  typedef enum logic [QTY_W-1:0] {
    QTY_VOLTAGE     = 4'd0,
    QTY_CHG_CURRENT = 4'd1,
    QTY_DSG_CURRENT = 4'd2,
    QTY_BAT_CURRENT = 4'd3,
    QTY_SOC         = 4'd4,
    QTY_TODAY_CHG   = 4'd5,
    QTY_TODAY_DSG   = 4'd6,
    QTY_STORED      = 4'd7,
    QTY_STATUS      = 4'd8,
    QTY_LIFE_CHG    = 4'd9,
    QTY_LIFE_DSG    = 4'd10,
    QTY_CELL_NUM    = 4'd11,
    QTY_CELL_MV     = 4'd12,
    QTY_CELL_TEMP   = 4'd13
  } qty_t;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Hand-over of one finished frame from the tracker to the result queue.
  typedef struct packed {
    logic                          valid;
    outcome_t                      outcome;
    logic [CNT_W-1:0]              count;
    value_t [QTY_COUNT-1:0]        vals;
  } frame_load_t;

endpackage

@@ src/bmfd_in_if.sv @@
`timescale 1ns / 1ps

interface bmfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

@@ src/bmfd_out_if.sv @@
`timescale 1ns / 1ps

interface bmfd_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         outcome;
  logic [bmfd_pkg::QTY_W-1:0]         quantity;
  logic signed [bmfd_pkg::VALUE_W-1:0] value;
  logic                               last;

  modport source (output valid, output outcome, output quantity, output value,
                  output last, input ready);
  modport sink (input valid, input outcome, input quantity, input value,
                input last, output ready);
endinterface

@@ src/battery_monitor_frame_decoder_unit.sv @@
`timescale 1ns / 1ps
// Channel   Role    Moves per transaction
// in_bus    sink    rx_byte, frame_end
// out_bus   source  outcome, quantity, value, last
//
// One byte is taken every cycle unless an end byte waits for the queue; each byte passes an
// input register, then the tracker, which on a frame end loads the result queue with 1, 11
// or 14 results. Results leave one per cycle from the queue head while out_bus is ready; the
// first becomes valid once the end byte has left the input register and loaded the queue.
// A frame end byte waits until the queue is empty or its last result is being taken.
// rst_n is synchronous: it clears the byte count, both sums, the held currents and the queue.

module battery_monitor_frame_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  bmfd_in_if.sink     in_bus,
  bmfd_out_if.source  out_bus
);

  bmfd_pkg::frame_load_t load;
  logic                  load_ok;

  bmfd_frame_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .load_ok (load_ok),
    .load    (load)
  );

  bmfd_result_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .load_ok (load_ok),
    .out_bus (out_bus)
  );

endmodule

@@ src/bmfd_frame_tracker.sv @@
`timescale 1ns / 1ps

module bmfd_frame_tracker (
  input  logic                  clk,
  input  logic                  rst_n,
  bmfd_in_if.sink               in_bus,
  input  logic                  load_ok,
  output bmfd_pkg::frame_load_t load
);

  localparam int SHIFT_DEPTH = bmfd_pkg::FRAME_BYTES - 1;
  localparam int CW          = bmfd_pkg::COUNT_W;

  logic                 in_vld_r;
  logic [7:0]           in_byte_r;
  logic                 in_end_r;
  logic                 advance;
  logic                 in_take;

  logic [7:0]           shift_r [SHIFT_DEPTH];
  logic [7:0]           pb [bmfd_pkg::PAYLOAD_BYTES];

  logic [CW-1:0]        count_r, count_nxt;
  logic [7:0]           sum_a_r, sum_a_nxt;
  logic [7:0]           sum_s_r, sum_s_nxt;
  logic signed [23:0]   held_r [3];
  logic signed [23:0]   cur_new [3];

  logic                 is_short, is_long, len_ok, sum_ok, good, cell_ok;
  logic [7:0]           expect_sum;
  logic [26:0]          volt_mv;
  logic [18:0]          cell_mv;
  logic signed [16:0]   cell_temp;
  bmfd_pkg::value_t [bmfd_pkg::QTY_COUNT-1:0] vals;

  assign advance       = in_vld_r && (!in_end_r || load_ok);
  assign in_bus.ready  = !in_vld_r || advance;
  assign in_take       = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_bus.rx_byte;
      in_end_r  <= in_bus.frame_end;
    end
  end

  // Byte history: the end byte sees payload byte k at a fixed tap for both lengths
  always_ff @(posedge clk) begin
    if (advance) begin
      shift_r[0] <= in_byte_r;
      for (int i = 1; i < SHIFT_DEPTH; i++) begin
        shift_r[i] <= shift_r[i-1];
      end
    end
  end

  for (genvar k = 0; k < bmfd_pkg::PAYLOAD_BYTES; k++) begin : g_tap
    assign pb[k] = shift_r[SHIFT_DEPTH-1-k];
  end

  assign is_short   = count_r == CW'(bmfd_pkg::FRAME_BYTES - 1);
  assign is_long    = count_r == CW'(bmfd_pkg::FRAME_BYTES);
  assign len_ok     = is_short || is_long;
  assign expect_sum = is_short ? sum_a_r : sum_s_r;
  assign sum_ok     = in_byte_r == expect_sum;
  assign good       = len_ok && sum_ok;

  always_comb begin
    count_nxt = count_r;
    sum_a_nxt = sum_a_r;
    sum_s_nxt = sum_s_r;
    if (in_end_r) begin
      count_nxt = '0;
      sum_a_nxt = '0;
      sum_s_nxt = '0;
    end else begin
      if (count_r <= CW'(bmfd_pkg::FRAME_BYTES - 2)) begin
        sum_a_nxt = sum_a_r + in_byte_r;
      end
      if (count_r != '0 && count_r <= CW'(bmfd_pkg::FRAME_BYTES - 1)) begin
        sum_s_nxt = sum_s_r + in_byte_r;
      end
      if (count_r != CW'(bmfd_pkg::COUNT_MAX)) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_a_r <= '0;
      sum_s_r <= '0;
    end else if (advance) begin
      count_r <= count_nxt;
      sum_a_r <= sum_a_nxt;
      sum_s_r <= sum_s_nxt;
    end
  end

  // Currents: 'X' holds, '-' negates, anything else is positive
  for (genvar j = 0; j < 3; j++) begin : g_cur
    logic [7:0]  marker;
    logic [22:0] scaled;
    assign marker = pb[3 + 3*j];
    assign scaled = 23'({pb[4 + 3*j], pb[5 + 3*j]}) * 23'(bmfd_pkg::CURRENT_SCALE);
    always_comb begin
      if (marker == bmfd_pkg::MARK_KEEP) begin
        cur_new[j] = held_r[j];
      end else if (marker == bmfd_pkg::MARK_NEG) begin
        cur_new[j] = -$signed({1'b0, scaled});
      end else begin
        cur_new[j] = $signed({1'b0, scaled});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        held_r[j] <= '0;
      end else if (advance && in_end_r && good) begin
        held_r[j] <= cur_new[j];
      end
    end
  end

  assign volt_mv   = 27'({pb[0], pb[1], pb[2]}) * 27'(bmfd_pkg::VOLT_SCALE);
  assign cell_mv   = 19'({pb[26], pb[27]}) * 19'(bmfd_pkg::VOLT_SCALE);
  assign cell_temp = $signed({1'b0, pb[28], pb[29]}) - 17'(bmfd_pkg::TEMP_OFFSET);
  assign cell_ok   = pb[24] != '0 && {1'b0, pb[24]} <= 9'(bmfd_pkg::CELL_COUNT);

  always_comb begin
    vals                            = '0;
    vals[bmfd_pkg::QTY_VOLTAGE]     = {1'b0, volt_mv};
    vals[bmfd_pkg::QTY_CHG_CURRENT] = 28'(cur_new[0]);
    vals[bmfd_pkg::QTY_DSG_CURRENT] = 28'(cur_new[1]);
    vals[bmfd_pkg::QTY_BAT_CURRENT] = 28'(cur_new[2]);
    vals[bmfd_pkg::QTY_SOC]         = {20'd0, pb[40]};
    vals[bmfd_pkg::QTY_TODAY_CHG]   = {4'd0, pb[31], pb[32], pb[33]};
    vals[bmfd_pkg::QTY_TODAY_DSG]   = {4'd0, pb[37], pb[38], pb[39]};
    vals[bmfd_pkg::QTY_STORED]      = {4'd0, pb[34], pb[35], pb[36]};
    vals[bmfd_pkg::QTY_STATUS]      = {20'd0, pb[30]};
    vals[bmfd_pkg::QTY_LIFE_CHG]    = {4'd0, pb[41], pb[42], pb[43]};
    vals[bmfd_pkg::QTY_LIFE_DSG]    = {4'd0, pb[44], pb[45], pb[46]};
    vals[bmfd_pkg::QTY_CELL_NUM]    = {20'd0, pb[24]};
    vals[bmfd_pkg::QTY_CELL_MV]     = {9'd0, cell_mv};
    vals[bmfd_pkg::QTY_CELL_TEMP]   = 28'(cell_temp);
  end

  always_comb begin
    load.valid = advance && in_end_r;
    if (!len_ok) begin
      load.outcome = bmfd_pkg::OUT_BAD_LEN;
    end else if (!sum_ok) begin
      load.outcome = bmfd_pkg::OUT_BAD_SUM;
    end else begin
      load.outcome = bmfd_pkg::OUT_GOOD;
    end
    if (!good) begin
      load.count = bmfd_pkg::CNT_W'(1);
      load.vals  = '0;
    end else begin
      load.count = cell_ok ? bmfd_pkg::CNT_W'(bmfd_pkg::QTY_COUNT)
                           : bmfd_pkg::CNT_W'(bmfd_pkg::QTY_NO_CELL);
      load.vals  = vals;
    end
  end

endmodule

@@ src/bmfd_result_queue.sv @@
`timescale 1ns / 1ps

module bmfd_result_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bmfd_pkg::frame_load_t load,
  output logic                  load_ok,
  bmfd_out_if.source            out_bus
);

  logic [bmfd_pkg::CNT_W-1:0]                  cnt_r;
  logic [bmfd_pkg::QTY_W-1:0]                  qty_r;
  bmfd_pkg::outcome_t                          outcome_r;
  bmfd_pkg::value_t [bmfd_pkg::QTY_COUNT-1:0]  val_r;
  logic                                        take;

  assign take             = out_bus.valid && out_bus.ready;
  assign out_bus.valid    = cnt_r != '0;
  assign out_bus.last     = cnt_r == bmfd_pkg::CNT_W'(1);
  assign out_bus.value    = val_r[0];
  assign out_bus.quantity = qty_r;
  assign out_bus.outcome  = outcome_r;

  // A new frame may drop in once the last result of the previous one leaves
  assign load_ok = (cnt_r == '0) || (cnt_r == bmfd_pkg::CNT_W'(1) && out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load.valid) begin
      cnt_r <= load.count;
    end else if (take) begin
      cnt_r <= cnt_r - bmfd_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      qty_r     <= bmfd_pkg::QTY_VOLTAGE;
      outcome_r <= load.outcome;
      val_r     <= load.vals;
    end else if (take) begin
      qty_r <= qty_r + bmfd_pkg::QTY_W'(1);
      for (int i = 0; i < bmfd_pkg::QTY_COUNT - 1; i++) begin
        val_r[i] <= val_r[i+1];
      end
    end
  end

endmodule

@@ src/bmfd_checker.sv @@
`timescale 1ns / 1ps
`include "battery_monitor_frame_decoder_unit_defines.svh"

module bmfd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [1:0]                          outcome,
  input logic [bmfd_pkg::QTY_W-1:0]          quantity,
  input logic signed [bmfd_pkg::VALUE_W-1:0] value,
  input logic                                last
);

  `BMFD_ASSERT_ALWAYS(a_quiet_after_reset, !rst_n |=> !out_valid, "result shown after reset")

  `BMFD_ASSERT(a_hold_on_stall, out_valid && !out_ready |=> out_valid && $stable(value) && $stable(quantity), "stalled result changed")

  `BMFD_ASSERT(a_frame_in_order, out_valid && out_ready && !last |=> out_valid && quantity == $past(quantity) + 4'd1 && outcome == $past(outcome), "frame results broken or out of order")

  `BMFD_ASSERT(a_error_single, out_valid && outcome != bmfd_pkg::OUT_GOOD |-> last && quantity == '0 && value == '0, "error result malformed")

  `BMFD_ASSERT(a_good_frame_end, out_valid && last && outcome == bmfd_pkg::OUT_GOOD |-> quantity == bmfd_pkg::QTY_LIFE_DSG || quantity == bmfd_pkg::QTY_CELL_TEMP, "good frame ends on wrong quantity")

endmodule

bind battery_monitor_frame_decoder_unit bmfd_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .outcome   (out_bus.outcome),
  .quantity  (out_bus.quantity),
  .value     (out_bus.value),
  .last      (out_bus.last)
);
